// ----- rtl/ahfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ahfc_pkg;

   localparam logic [7:0] START_BYTE    = 8'h7E;
   localparam logic [7:0] END_BYTE      = 8'h0D;
   localparam logic [7:0] MIN_FRAME_LEN = 8'd18;
   localparam logic [7:0] MAX_LEN_RESET = 8'd100;
   localparam logic [7:0] COUNT_LIMIT   = 8'd255;
   localparam logic [7:0] HDR_LAST_POS  = 8'd12;
   localparam logic [7:0] SUM_FIRST_POS = 8'd5;
   localparam logic [7:0] CID1_BATTERY  = 8'h46;
   localparam logic [7:0] CID2_SYS_INFO = 8'h61;
   localparam logic [7:0] CID2_BAT_INFO = 8'h62;
   localparam logic [7:0] CID2_ALARMS   = 8'h63;
   localparam int         HDR_BYTES     = 6;
   localparam int         RECENT_BYTES  = 4;

   localparam logic [2:0] HDR_VERSION = 3'd0;
   localparam logic [2:0] HDR_ADDRESS = 3'd1;
   localparam logic [2:0] HDR_CID1    = 3'd2;
   localparam logic [2:0] HDR_CID2    = 3'd3;
   localparam logic [2:0] HDR_LEN_H   = 3'd4;
   localparam logic [2:0] HDR_LEN_L   = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_LEN_CHK = 2'd2,
      STATUS_SUM_CHK = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_OTHER    = 2'd0,
      KIND_SYS_INFO = 2'd1,
      KIND_BAT_INFO = 2'd2,
      KIND_ALARMS   = 2'd3
   } kind_type;

   // ASCII hex digit to nibble; anything else decodes as zero
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = c[3:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = c[3:0] + 4'd9;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ascii_hex_frame_checker.sv -----
// Each request byte is taken into an input register and then processed into the frame state;
// a frame's response is registered from the processing of its end byte.
// Throughput: one byte per cycle; the response register stalls the byte path only while a
// pending response is not taken.
// Reset clears the frame state and the valid bits of both pipeline registers, and sets the length limit to 100.
`timescale 1ns / 1ps
`default_nettype none

module ascii_hex_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_version,
   output logic [7:0]       rsp_address,
   output logic [7:0]       rsp_cid1,
   output logic [7:0]       rsp_cid2,
   output logic [11:0]      rsp_info_len,
   output logic [1:0]       rsp_request_kind,
   output logic [7:0]       rsp_frame_len,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic [7:0] max_frame_len_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       advance;

   logic       in_frame_ff,  in_frame_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [7:0] header_ff [ahfc_pkg::HDR_BYTES];
   logic [7:0] header_in [ahfc_pkg::HDR_BYTES];
   logic [15:0] sum_ff, sum_in;
   logic [7:0] recent_ff [ahfc_pkg::RECENT_BYTES];
   logic [7:0] recent_in [ahfc_pkg::RECENT_BYTES];

   logic               emit;
   ahfc_pkg::status_type res_status;
   ahfc_pkg::kind_type   res_kind;
   logic [7:0]         res_version, res_address, res_cid1, res_cid2, res_len;
   logic [11:0]        res_info_len;

   logic                 rsp_valid_ff;
   ahfc_pkg::status_type rsp_status_ff;
   ahfc_pkg::kind_type   rsp_kind_ff;
   logic [7:0]           rsp_version_ff, rsp_address_ff, rsp_cid1_ff, rsp_cid2_ff;
   logic [7:0]           rsp_frame_len_ff;
   logic [11:0]          rsp_info_len_ff;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= ahfc_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_frame_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [7:0]  p;
      logic [7:0]  p_next;
      logic [2:0]  hdr_idx;
      logic        clear;
      logic [15:0] len_word;
      logic [3:0]  len_sum;
      logic [15:0] rx_sum;
      logic [15:0] calc_sum;

      b        = s1_byte_ff;
      p        = byte_count_ff;
      p_next   = p + 8'd1;
      hdr_idx  = p[3:1] - 3'd1;
      clear    = 1'b0;
      emit     = 1'b0;

      in_frame_in    = in_frame_ff;
      byte_count_in  = byte_count_ff;
      high_nibble_in = high_nibble_ff;
      sum_in         = sum_ff;
      for (int i = 0; i < ahfc_pkg::HDR_BYTES; i++) begin
         header_in[i] = header_ff[i];
      end
      for (int i = 0; i < ahfc_pkg::RECENT_BYTES; i++) begin
         recent_in[i] = recent_ff[i];
      end

      if (!in_frame_ff) begin
         if (b == ahfc_pkg::START_BYTE) begin
            clear         = 1'b1;
            in_frame_in   = (max_frame_len_ff != 8'd0);
            byte_count_in = (max_frame_len_ff != 8'd0) ? 8'd1 : 8'd0;
         end
      end else if (p == ahfc_pkg::COUNT_LIMIT) begin
         clear       = 1'b1;
         in_frame_in = 1'b0;
         byte_count_in = 8'd0;
      end else if (b == ahfc_pkg::END_BYTE) begin
         emit          = 1'b1;
         clear         = 1'b1;
         in_frame_in   = 1'b0;
         byte_count_in = 8'd0;
      end else if (p_next > max_frame_len_ff) begin
         clear         = 1'b1;
         in_frame_in   = 1'b0;
         byte_count_in = 8'd0;
      end else begin
         byte_count_in = p_next;
         if (p >= 8'd1 && p <= ahfc_pkg::HDR_LAST_POS) begin
            if (p[0]) begin
               high_nibble_in = ahfc_pkg::hex_nibble(b);
            end else begin
               header_in[hdr_idx] = {high_nibble_ff, ahfc_pkg::hex_nibble(b)};
            end
         end
         if (p >= ahfc_pkg::SUM_FIRST_POS) begin
            sum_in = sum_ff + {8'd0, recent_ff[0]};
         end
         for (int i = 0; i < ahfc_pkg::RECENT_BYTES - 1; i++) begin
            recent_in[i] = recent_ff[i + 1];
         end
         recent_in[ahfc_pkg::RECENT_BYTES - 1] = b;
      end

      if (clear) begin
         high_nibble_in = 4'd0;
         sum_in         = 16'd0;
         for (int i = 0; i < ahfc_pkg::HDR_BYTES; i++) begin
            header_in[i] = 8'd0;
         end
         for (int i = 0; i < ahfc_pkg::RECENT_BYTES; i++) begin
            recent_in[i] = 8'd0;
         end
      end

      // end-of-frame checks
      len_word = {header_ff[ahfc_pkg::HDR_LEN_H], header_ff[ahfc_pkg::HDR_LEN_L]};
      len_sum  = len_word[3:0] + len_word[7:4] + len_word[11:8];
      rx_sum   = {ahfc_pkg::hex_nibble(recent_ff[0]), ahfc_pkg::hex_nibble(recent_ff[1]),
                  ahfc_pkg::hex_nibble(recent_ff[2]), ahfc_pkg::hex_nibble(recent_ff[3])};
      calc_sum = 16'd0 - sum_ff;

      res_len      = p_next;
      res_version  = header_ff[ahfc_pkg::HDR_VERSION];
      res_address  = header_ff[ahfc_pkg::HDR_ADDRESS];
      res_cid1     = header_ff[ahfc_pkg::HDR_CID1];
      res_cid2     = header_ff[ahfc_pkg::HDR_CID2];
      res_info_len = len_word[11:0];
      res_kind     = ahfc_pkg::KIND_OTHER;

      priority if (p_next < ahfc_pkg::MIN_FRAME_LEN) begin
         res_status   = ahfc_pkg::STATUS_SHORT;
         res_version  = 8'd0;
         res_address  = 8'd0;
         res_cid1     = 8'd0;
         res_cid2     = 8'd0;
         res_info_len = 12'd0;
      end else if ((4'd0 - len_sum) != len_word[15:12]) begin
         res_status = ahfc_pkg::STATUS_LEN_CHK;
      end else if (calc_sum != rx_sum) begin
         res_status = ahfc_pkg::STATUS_SUM_CHK;
      end else begin
         res_status = ahfc_pkg::STATUS_OK;
         if (res_cid1 == ahfc_pkg::CID1_BATTERY) begin
            priority if (res_cid2 == ahfc_pkg::CID2_SYS_INFO) begin
               res_kind = ahfc_pkg::KIND_SYS_INFO;
            end else if (res_cid2 == ahfc_pkg::CID2_BAT_INFO) begin
               res_kind = ahfc_pkg::KIND_BAT_INFO;
            end else if (res_cid2 == ahfc_pkg::CID2_ALARMS) begin
               res_kind = ahfc_pkg::KIND_ALARMS;
            end else begin
               res_kind = ahfc_pkg::KIND_OTHER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         byte_count_ff  <= 8'd0;
         high_nibble_ff <= 4'd0;
         sum_ff         <= 16'd0;
         for (int i = 0; i < ahfc_pkg::HDR_BYTES; i++) begin
            header_ff[i] <= 8'd0;
         end
         for (int i = 0; i < ahfc_pkg::RECENT_BYTES; i++) begin
            recent_ff[i] <= 8'd0;
         end
      end else if (advance) begin
         in_frame_ff    <= in_frame_in;
         byte_count_ff  <= byte_count_in;
         high_nibble_ff <= high_nibble_in;
         sum_ff         <= sum_in;
         for (int i = 0; i < ahfc_pkg::HDR_BYTES; i++) begin
            header_ff[i] <= header_in[i];
         end
         for (int i = 0; i < ahfc_pkg::RECENT_BYTES; i++) begin
            recent_ff[i] <= recent_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_status_ff    <= res_status;
         rsp_kind_ff      <= res_kind;
         rsp_version_ff   <= res_version;
         rsp_address_ff   <= res_address;
         rsp_cid1_ff      <= res_cid1;
         rsp_cid2_ff      <= res_cid2;
         rsp_info_len_ff  <= res_info_len;
         rsp_frame_len_ff <= res_len;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_request_kind = rsp_kind_ff;
   assign rsp_version      = rsp_version_ff;
   assign rsp_address      = rsp_address_ff;
   assign rsp_cid1         = rsp_cid1_ff;
   assign rsp_cid2         = rsp_cid2_ff;
   assign rsp_info_len     = rsp_info_len_ff;
   assign rsp_frame_len    = rsp_frame_len_ff;

endmodule

`default_nettype wire

// ----- verif/ascii_hex_frame_checker_tb.sv -----
`timescale 1ns / 1ps

module ascii_hex_frame_checker_tb;

   localparam int         CYCLE_LIMIT   = 300000;
   localparam int         IDLE_PCT      = 18;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         TOTAL_BYTES   = 1150;
   localparam int         PHASES        = 6;
   localparam logic [7:0] IDLE_BYTE     = 8'hFF;

   typedef struct {
      ahfc_pkg::status_type status;
      logic [7:0]           version;
      logic [7:0]           address;
      logic [7:0]           cid1;
      logic [7:0]           cid2;
      logic [11:0]          info_len;
      ahfc_pkg::kind_type   kind;
      logic [7:0]           frame_len;
   } frame_report_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_version;
   logic [7:0]  rsp_address;
   logic [7:0]  rsp_cid1;
   logic [7:0]  rsp_cid2;
   logic [11:0] rsp_info_len;
   logic [1:0]  rsp_request_kind;
   logic [7:0]  rsp_frame_len;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   // frame tracker state
   logic [7:0]  frame_limit;
   bit          frame_open;
   logic [7:0]  frame_count;
   logic [3:0]  pending_high;
   logic [7:0]  header_field[ahfc_pkg::HDR_BYTES];
   logic [15:0] char_sum;
   logic [7:0]  tail_chars[ahfc_pkg::RECENT_BYTES];

   frame_report_type pending_reports[$];
   logic [7:0]       frame_bytes[$];

   int send_idle_pct = IDLE_PCT;
   int stall_pct = IDLE_PCT;
   int bytes_sent = 0;
   int framed_bytes = 0;
   int reports_checked = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   ascii_hex_frame_checker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_version      (rsp_version),
      .rsp_address      (rsp_address),
      .rsp_cid1         (rsp_cid1),
      .rsp_cid2         (rsp_cid2),
      .rsp_info_len     (rsp_info_len),
      .rsp_request_kind (rsp_request_kind),
      .rsp_frame_len    (rsp_frame_len),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [3:0] char_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
      return 4'd0;
   endfunction

   function automatic void clear_frame_state();
      frame_open = 1'b0;
      frame_count = 8'd0;
      pending_high = 4'd0;
      char_sum = 16'd0;
      foreach (header_field[i]) header_field[i] = 8'd0;
      foreach (tail_chars[i]) tail_chars[i] = 8'd0;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      frame_bytes.insert(frame_bytes.size(), b);
   endfunction

   // returns 1 when the byte closes a frame with a report
   function automatic bit track_frame_byte(input logic [7:0] b, output frame_report_type r);
      logic [7:0]  pos;
      logic [15:0] len_word;
      logic [15:0] rx_sum;
      logic [3:0]  len_chk;
      r.status = ahfc_pkg::STATUS_OK;
      r.version = 8'd0;
      r.address = 8'd0;
      r.cid1 = 8'd0;
      r.cid2 = 8'd0;
      r.info_len = 12'd0;
      r.kind = ahfc_pkg::KIND_OTHER;
      r.frame_len = 8'd0;
      if (!frame_open) begin
         if (b != ahfc_pkg::START_BYTE) return 1'b0;
         clear_frame_state();
         frame_open = 1'b1;
         frame_count = 8'd1;
         if (frame_count > frame_limit) clear_frame_state();
         return 1'b0;
      end
      pos = frame_count;
      if (pos == ahfc_pkg::COUNT_LIMIT) begin
         clear_frame_state();
         return 1'b0;
      end
      if (b == ahfc_pkg::END_BYTE) begin
         r.frame_len = pos + 8'd1;
         if (r.frame_len < ahfc_pkg::MIN_FRAME_LEN) begin
            r.status = ahfc_pkg::STATUS_SHORT;
         end else begin
            len_word = {header_field[ahfc_pkg::HDR_LEN_H], header_field[ahfc_pkg::HDR_LEN_L]};
            len_chk = 4'd0 - (len_word[3:0] + len_word[7:4] + len_word[11:8]);
            rx_sum = {char_value(tail_chars[0]), char_value(tail_chars[1]),
                      char_value(tail_chars[2]), char_value(tail_chars[3])};
            r.version = header_field[ahfc_pkg::HDR_VERSION];
            r.address = header_field[ahfc_pkg::HDR_ADDRESS];
            r.cid1 = header_field[ahfc_pkg::HDR_CID1];
            r.cid2 = header_field[ahfc_pkg::HDR_CID2];
            r.info_len = len_word[11:0];
            if (len_chk != len_word[15:12]) begin
               r.status = ahfc_pkg::STATUS_LEN_CHK;
            end else if (16'd0 - char_sum != rx_sum) begin
               r.status = ahfc_pkg::STATUS_SUM_CHK;
            end else if (r.cid1 == ahfc_pkg::CID1_BATTERY) begin
               case (r.cid2)
                  ahfc_pkg::CID2_SYS_INFO: r.kind = ahfc_pkg::KIND_SYS_INFO;
                  ahfc_pkg::CID2_BAT_INFO: r.kind = ahfc_pkg::KIND_BAT_INFO;
                  ahfc_pkg::CID2_ALARMS:   r.kind = ahfc_pkg::KIND_ALARMS;
                  default:                 r.kind = ahfc_pkg::KIND_OTHER;
               endcase
            end
         end
         clear_frame_state();
         return 1'b1;
      end
      frame_count = pos + 8'd1;
      if (frame_count > frame_limit) begin
         clear_frame_state();
         return 1'b0;
      end
      if (pos >= 8'd1 && pos <= ahfc_pkg::HDR_LAST_POS) begin
         if (pos[0]) pending_high = char_value(b);
         else header_field[pos[3:1] - 3'd1] = {pending_high, char_value(b)};
      end
      if (pos >= ahfc_pkg::SUM_FIRST_POS) char_sum = char_sum + {8'd0, tail_chars[0]};
      tail_chars[0] = tail_chars[1];
      tail_chars[1] = tail_chars[2];
      tail_chars[2] = tail_chars[3];
      tail_chars[3] = b;
      return 1'b0;
   endfunction

   function automatic void compare_field(input string name, input logic [11:0] want,
                                         input logic [11:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      frame_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("frame report with none outstanding");
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("status", 12'(want.status), 12'(rsp_status));
            compare_field("version", 12'(want.version), 12'(rsp_version));
            compare_field("address", 12'(want.address), 12'(rsp_address));
            compare_field("cid1", 12'(want.cid1), 12'(rsp_cid1));
            compare_field("cid2", 12'(want.cid2), 12'(rsp_cid2));
            compare_field("info_len", want.info_len, rsp_info_len);
            compare_field("request_kind", 12'(want.kind), 12'(rsp_request_kind));
            compare_field("frame_len", 12'(want.frame_len), 12'(rsp_frame_len));
            reports_checked++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout with %0d frame reports outstanding", pending_reports.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      frame_report_type rep;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (frame_open || b == ahfc_pkg::START_BYTE) framed_bytes++;
      if (track_frame_byte(b, rep)) pending_reports.insert(pending_reports.size(), rep);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_limit(input logic [7:0] limit);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      frame_limit = limit;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + {4'd0, n};
      return (lower ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
   endfunction

   function automatic void append_hex(input logic [15:0] v, input int digits, input bit lower);
      for (int i = digits - 1; i >= 0; i--) add_byte(hex_char(v[4*i +: 4], lower));
   endfunction

   function automatic void open_frame(input logic [7:0] ver, input logic [7:0] adr,
                                      input logic [7:0] c1, input logic [7:0] c2,
                                      input logic [11:0] info, input bit bad_len,
                                      input bit lower);
      logic [3:0] chk;
      chk = 4'd0 - (info[3:0] + info[7:4] + info[11:8]);
      if (bad_len) chk = chk + 4'($urandom_range(1, 15));
      frame_bytes.delete();
      add_byte(ahfc_pkg::START_BYTE);
      append_hex({8'd0, ver}, 2, lower);
      append_hex({8'd0, adr}, 2, lower);
      append_hex({8'd0, c1}, 2, lower);
      append_hex({8'd0, c2}, 2, lower);
      append_hex({chk, info}, 4, lower);
   endfunction

   // raw_pct: share of payload bytes that are arbitrary instead of hex digits
   function automatic void append_payload(input int count, input int raw_pct);
      logic [7:0] b;
      repeat (count) begin
         if ($urandom_range(99) < raw_pct) begin
            b = 8'($urandom);
            if (b == ahfc_pkg::END_BYTE) b = IDLE_BYTE;
         end else begin
            b = hex_char(4'($urandom), 1'b0);
         end
         add_byte(b);
      end
   endfunction

   function automatic void seal_frame(input bit bad_sum, input bit lower);
      logic [15:0] sum;
      sum = 16'd0;
      for (int i = 1; i < frame_bytes.size(); i++) sum = sum + {8'd0, frame_bytes[i]};
      sum = 16'd0 - sum;
      if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(15));
      append_hex(sum, 4, lower);
      add_byte(ahfc_pkg::END_BYTE);
   endfunction

   task automatic send_good_frame(input logic [7:0] ver, input logic [7:0] adr,
                                  input logic [7:0] c1, input logic [7:0] c2,
                                  input logic [11:0] info, input int payload_len);
      open_frame(ver, adr, c1, c2, info, 1'b0, 1'b0);
      append_payload(payload_len, 0);
      seal_frame(1'b0, 1'b0);
      send_frame();
   endtask

   task automatic test_idle_bytes();
      logic [7:0] noise[6] = '{IDLE_BYTE, ahfc_pkg::END_BYTE, 8'h00, 8'h7F, 8'h81, IDLE_BYTE};
      foreach (noise[i]) send_byte(noise[i]);
   endtask

   task automatic test_request_kinds();
      send_good_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_SYS_INFO, 12'd0, 0);
      send_good_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_BAT_INFO, 12'd2, 2);
      send_good_frame(8'h20, 8'h12, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_ALARMS, 12'd4, 4);
      send_good_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, 8'h60, 12'd0, 0);
      send_good_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, 8'h64, 12'd0, 0);
      send_good_frame(8'h20, 8'h02, 8'h45, ahfc_pkg::CID2_SYS_INFO, 12'd0, 0);
   endtask

   task automatic test_header_extremes();
      send_good_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 12'hFFF, 0);
      send_good_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 12'h000, 3);
      // lowercase hex decodes as zero
      open_frame(8'hAB, 8'hCD, ahfc_pkg::CID1_BATTERY, 8'h6F, 12'h0EF, 1'b0, 1'b1);
      seal_frame(1'b0, 1'b1);
      send_frame();
      // non-hex characters in the header
      open_frame(8'h25, 8'h01, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_BAT_INFO, 12'd0,
                 1'b0, 1'b0);
      frame_bytes[1] = 8'h47;
      frame_bytes[4] = IDLE_BYTE;
      frame_bytes[6] = ahfc_pkg::START_BYTE;
      seal_frame(1'b0, 1'b0);
      send_frame();
   endtask

   task automatic test_short_frames();
      frame_bytes = '{ahfc_pkg::START_BYTE, ahfc_pkg::END_BYTE};
      send_frame();
      frame_bytes = '{ahfc_pkg::START_BYTE, ahfc_pkg::START_BYTE, ahfc_pkg::END_BYTE};
      send_frame();
      open_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_SYS_INFO, 12'd0,
                 1'b0, 1'b0);
      append_payload(3, 0);
      add_byte(ahfc_pkg::END_BYTE);
      send_frame();
   endtask

   task automatic test_rejected_frames();
      open_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_SYS_INFO, 12'd6,
                 1'b1, 1'b0);
      append_payload(6, 0);
      seal_frame(1'b0, 1'b0);
      send_frame();
      open_frame(8'h20, 8'h02, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_BAT_INFO, 12'd2,
                 1'b0, 1'b0);
      append_payload(2, 0);
      seal_frame(1'b1, 1'b0);
      send_frame();
      // length check wins over frame checksum
      open_frame(8'h20, 8'h03, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_ALARMS, 12'd0,
                 1'b1, 1'b0);
      seal_frame(1'b1, 1'b0);
      send_frame();
   endtask

   task automatic test_frame_data_bytes();
      open_frame(8'h20, 8'h04, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_SYS_INFO, 12'd4,
                 1'b0, 1'b0);
      add_byte(ahfc_pkg::START_BYTE);
      add_byte(IDLE_BYTE);
      add_byte(8'h61);
      add_byte(8'h00);
      seal_frame(1'b0, 1'b0);
      send_frame();
   endtask

   task automatic test_length_limits();
      set_frame_limit(ahfc_pkg::MIN_FRAME_LEN);
      send_good_frame(8'h20, 8'h05, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_SYS_INFO, 12'd0, 0);
      // end byte one past the limit still reports
      send_good_frame(8'h20, 8'h05, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_BAT_INFO, 12'd1, 1);
      send_good_frame(8'h20, 8'h05, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_ALARMS, 12'd2, 2);
      send_good_frame(8'h20, 8'h06, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_SYS_INFO, 12'd0, 0);
      set_frame_limit(ahfc_pkg::COUNT_LIMIT);
      // 256th byte drops the frame even when it is the end byte
      send_good_frame(8'h20, 8'h07, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_BAT_INFO,
                      12'd238, 238);
      send_good_frame(8'h20, 8'h08, ahfc_pkg::CID1_BATTERY, ahfc_pkg::CID2_ALARMS, 12'd1, 1);
   endtask

   task automatic send_random_frame();
      int          pick;
      int          payload_len;
      int          cut;
      logic [7:0]  ver;
      logic [7:0]  adr;
      logic [7:0]  c1;
      logic [7:0]  c2;
      logic [7:0]  b;
      logic [11:0] info;
      bit          lower;
      if (frame_open) send_byte(ahfc_pkg::END_BYTE);
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 4)) begin
            b = ($urandom_range(2) == 0) ? IDLE_BYTE : 8'($urandom);
            if (b == ahfc_pkg::START_BYTE) b = IDLE_BYTE;
            send_byte(b);
         end
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
         frame_bytes.delete();
         add_byte(ahfc_pkg::START_BYTE);
         repeat ($urandom_range(0, 30)) add_byte(8'($urandom));
         add_byte(ahfc_pkg::END_BYTE);
         send_frame();
         return;
      end
      ver = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h20;
      adr = 8'($urandom);
      c1 = $urandom_range(1) ? ahfc_pkg::CID1_BATTERY : 8'($urandom);
      c2 = $urandom_range(2) ? 8'(ahfc_pkg::CID2_SYS_INFO + $urandom_range(2)) : 8'($urandom);
      payload_len = ($urandom_range(99) < 3) ? $urandom_range(0, 237) : $urandom_range(0, 24);
      info = ($urandom_range(9) == 0) ? 12'($urandom) : 12'(payload_len);
      lower = ($urandom_range(99) < 5);
      open_frame(ver, adr, c1, c2, info, pick < 10, lower);
      append_payload(payload_len, 4);
      seal_frame(pick >= 10 && pick < 16, lower);
      if (pick >= 16 && pick < 22) begin
         frame_bytes[$urandom_range(1, frame_bytes.size() - 2)] = 8'($urandom);
      end else if (pick >= 22 && pick < 27) begin
         cut = $urandom_range(1, frame_bytes.size() - 2);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         add_byte(ahfc_pkg::END_BYTE);
      end
      send_frame();
   endtask

   task automatic test_random_traffic();
      logic [7:0] limits[PHASES];
      int         budget;
      int         share;
      limits = '{ahfc_pkg::MAX_LEN_RESET, ahfc_pkg::MIN_FRAME_LEN, ahfc_pkg::COUNT_LIMIT,
                 8'd47, 8'd0, ahfc_pkg::MAX_LEN_RESET};
      limits[4] = 8'($urandom_range(ahfc_pkg::MIN_FRAME_LEN, ahfc_pkg::COUNT_LIMIT));
      share = (TOTAL_BYTES > bytes_sent) ? (TOTAL_BYTES - bytes_sent) / PHASES : 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         set_frame_limit(limits[ph]);
         // one phase runs with no gaps on either side
         send_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         stall_pct = send_idle_pct;
         budget = bytes_sent + share;
         do send_random_frame(); while (bytes_sent < budget);
      end
      send_idle_pct = IDLE_PCT;
      stall_pct = IDLE_PCT;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'd0;
      rsp_ready <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 8'd0;
      frame_limit = ahfc_pkg::MAX_LEN_RESET;
      clear_frame_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_bytes();
      test_request_kinds();
      test_header_extremes();
      test_short_frames();
      test_rejected_frames();
      test_frame_data_bytes();
      test_length_limits();
      test_random_traffic();
      settle();

      $display("%0d request bytes (%0d in frames), %0d frame reports checked",
               bytes_sent, framed_bytes, reports_checked);
      $display("frame limits 18 to 255, short/bad-length/bad-sum/dropped frames, gaps both sides");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/ahfc_pkg.sv
rtl/ascii_hex_frame_checker.sv
verif/ascii_hex_frame_checker_tb.sv
